// ===== src/line_segment_rect_clipper_top_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef LINE_SEGMENT_RECT_CLIPPER_TOP_MACROS_SVH
`define LINE_SEGMENT_RECT_CLIPPER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line segment clipper check failed");

// The consequent must hold in the cycle after the antecedent.
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line segment clipper check failed");

`endif

// ===== src/lbc_pkg.sv =====
package lbc_pkg;

    localparam int T_FRAC_BITS = 16;
    localparam int MAX_T_FRAC  = 24;

    localparam int COORD_W = 20;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int DIST_W  = COORD_W + 2;
    localparam int MAG_W   = COORD_W + 1;
    localparam int RECT_W  = 19;
    localparam int LANES   = 4;

    localparam int REM_W  = MAG_W + MAX_T_FRAC + 2;
    localparam int QUO_W  = MAX_T_FRAC + 2;
    localparam int T_W    = QUO_W + 1;
    localparam int PROD_W = DIFF_W + T_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT = 2'd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic                      strict_mode;
    } seg_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] clip_start_x;
        logic signed [COORD_W-1:0] clip_start_y;
        logic signed [COORD_W-1:0] clip_end_x;
        logic signed [COORD_W-1:0] clip_end_y;
    } clip_t;

    // One edge test on its way through the divider.
    typedef struct packed {
        logic             pz;
        logic             pneg;
        logic             neg;
        logic             ovf;
        logic [MAG_W-1:0] den;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic                      reject;
    } carry_t;

endpackage

// ===== src/lbc_front.sv =====
module lbc_front #(
    parameter int TF = lbc_pkg::T_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        en,
    input  lbc_pkg::seg_t               seg,
    input  logic [lbc_pkg::RECT_W-1:0]  rect_width,
    input  logic [lbc_pkg::RECT_W-1:0]  rect_height,
    output lbc_pkg::lane_t [lbc_pkg::LANES-1:0] lanes,
    output lbc_pkg::carry_t             carry
);

    lbc_pkg::lane_t [lbc_pkg::LANES-1:0] lanes_reg;
    lbc_pkg::lane_t [lbc_pkg::LANES-1:0] lanes_next;
    lbc_pkg::carry_t                     carry_reg;
    lbc_pkg::carry_t                     carry_next;

    always_comb
    begin
        logic signed [lbc_pkg::DIFF_W-1:0] dx;
        logic signed [lbc_pkg::DIFF_W-1:0] dy;
        logic signed [lbc_pkg::DIFF_W-1:0] p [lbc_pkg::LANES];
        logic signed [lbc_pkg::DIST_W-1:0] q [lbc_pkg::LANES];
        logic [lbc_pkg::DIFF_W-1:0] pmag;
        logic [lbc_pkg::DIST_W-1:0] qmag;
        logic reject;
        dx = {seg.end_x[lbc_pkg::COORD_W-1], seg.end_x}
           - {seg.start_x[lbc_pkg::COORD_W-1], seg.start_x};
        dy = {seg.end_y[lbc_pkg::COORD_W-1], seg.end_y}
           - {seg.start_y[lbc_pkg::COORD_W-1], seg.start_y};
        p[0] = -dx;
        p[1] = dx;
        p[2] = -dy;
        p[3] = dy;
        q[0] = {{2{seg.start_x[lbc_pkg::COORD_W-1]}}, seg.start_x};
        q[1] = $signed({3'b000, rect_width})
             - $signed({{2{seg.start_x[lbc_pkg::COORD_W-1]}}, seg.start_x});
        q[2] = {{2{seg.start_y[lbc_pkg::COORD_W-1]}}, seg.start_y};
        q[3] = $signed({3'b000, rect_height})
             - $signed({{2{seg.start_y[lbc_pkg::COORD_W-1]}}, seg.start_y});
        reject = 1'b0;
        for (int k = 0; k < lbc_pkg::LANES; k++)
        begin
            pmag = p[k][lbc_pkg::DIFF_W-1] ? -p[k] : p[k];
            qmag = q[k][lbc_pkg::DIST_W-1] ? -q[k] : q[k];
            lanes_next[k].pz   = (p[k] == '0);
            lanes_next[k].pneg = p[k][lbc_pkg::DIFF_W-1];
            lanes_next[k].neg  = p[k][lbc_pkg::DIFF_W-1] ^ q[k][lbc_pkg::DIST_W-1];
            lanes_next[k].den  = pmag[lbc_pkg::MAG_W-1:0];
            lanes_next[k].ovf  = ({2'b00, qmag[lbc_pkg::MAG_W-1:0]}
                                  >= {pmag[lbc_pkg::MAG_W-1:0], 2'b00});
            lanes_next[k].rem  = lbc_pkg::REM_W'(qmag[lbc_pkg::MAG_W-1:0]) << TF;
            lanes_next[k].quo  = '0;
            if (p[k] == '0)
            begin
                if (q[k][lbc_pkg::DIST_W-1] || (seg.strict_mode && q[k] == '0))
                begin
                    reject = 1'b1;
                end
            end
        end
        carry_next.sx     = seg.start_x;
        carry_next.sy     = seg.start_y;
        carry_next.dx     = dx;
        carry_next.dy     = dy;
        carry_next.reject = reject;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
            carry_reg <= carry_next;
        end
    end

    assign lanes = lanes_reg;
    assign carry = carry_reg;

endmodule

// ===== src/lbc_div_pipe.sv =====
module lbc_div_pipe #(
    parameter int NDIV = lbc_pkg::T_FRAC_BITS + 2
) (
    input  logic                                clk,
    input  logic [NDIV-1:0]                     en,
    input  lbc_pkg::lane_t [lbc_pkg::LANES-1:0] lanes_in,
    input  lbc_pkg::carry_t                     carry_in,
    output lbc_pkg::lane_t [lbc_pkg::LANES-1:0] lanes_out,
    output lbc_pkg::carry_t                     carry_out
);

    lbc_pkg::lane_t [lbc_pkg::LANES-1:0] lanes_reg [NDIV];
    lbc_pkg::carry_t                     carry_reg [NDIV];

    for (genvar s = 0; s < NDIV; s++)
    begin : g_step
        lbc_pkg::lane_t [lbc_pkg::LANES-1:0] src;
        lbc_pkg::carry_t                     csrc;
        lbc_pkg::lane_t [lbc_pkg::LANES-1:0] lanes_next;

        if (s == 0)
        begin : g_first
            assign src  = lanes_in;
            assign csrc = carry_in;
        end
        else
        begin : g_rest
            assign src  = lanes_reg[s-1];
            assign csrc = carry_reg[s-1];
        end

        always_comb
        begin
            logic [lbc_pkg::REM_W-1:0] sub;
            for (int k = 0; k < lbc_pkg::LANES; k++)
            begin
                lanes_next[k] = src[k];
                sub = lbc_pkg::REM_W'(src[k].den) << (NDIV - 1 - s);
                if (!src[k].ovf && src[k].rem >= sub)
                begin
                    lanes_next[k].rem = src[k].rem - sub;
                    lanes_next[k].quo[NDIV - 1 - s] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                lanes_reg[s] <= lanes_next;
                carry_reg[s] <= csrc;
            end
        end
    end

    assign lanes_out = lanes_reg[NDIV-1];
    assign carry_out = carry_reg[NDIV-1];

endmodule

// ===== src/lbc_back.sv =====
module lbc_back #(
    parameter int TF = lbc_pkg::T_FRAC_BITS
) (
    input  logic                                clk,
    input  logic [2:0]                          en,
    input  lbc_pkg::lane_t [lbc_pkg::LANES-1:0] lanes,
    input  lbc_pkg::carry_t                     carry,
    output lbc_pkg::clip_t                      clip
);

    localparam logic signed [lbc_pkg::T_W-1:0] ONE  = lbc_pkg::T_W'(1) << TF;
    localparam logic signed [lbc_pkg::T_W-1:0] TWO  = lbc_pkg::T_W'(2) << TF;
    localparam logic signed [lbc_pkg::PROD_W-1:0] HALF = lbc_pkg::PROD_W'(1) << (TF - 1);

    typedef struct packed {
        logic                              hit;
        logic signed [lbc_pkg::T_W-1:0]    near;
        logic signed [lbc_pkg::T_W-1:0]    far;
        logic signed [lbc_pkg::COORD_W-1:0] sx;
        logic signed [lbc_pkg::COORD_W-1:0] sy;
        logic signed [lbc_pkg::DIFF_W-1:0]  dx;
        logic signed [lbc_pkg::DIFF_W-1:0]  dy;
    } span_t;

    typedef struct packed {
        logic                               hit;
        logic signed [lbc_pkg::COORD_W-1:0] sx;
        logic signed [lbc_pkg::COORD_W-1:0] sy;
        logic signed [lbc_pkg::PROD_W-1:0]  xn;
        logic signed [lbc_pkg::PROD_W-1:0]  yn;
        logic signed [lbc_pkg::PROD_W-1:0]  xf;
        logic signed [lbc_pkg::PROD_W-1:0]  yf;
    } prod_t;

    span_t          span_reg;
    span_t          span_next;
    prod_t          prod_reg;
    prod_t          prod_next;
    lbc_pkg::clip_t clip_reg;
    lbc_pkg::clip_t clip_next;

    always_comb
    begin
        logic signed [lbc_pkg::T_W-1:0] mag;
        logic signed [lbc_pkg::T_W-1:0] t;
        logic signed [lbc_pkg::T_W-1:0] near;
        logic signed [lbc_pkg::T_W-1:0] far;
        near = '0;
        far  = ONE;
        for (int k = 0; k < lbc_pkg::LANES; k++)
        begin
            mag = $signed({1'b0, lanes[k].quo});
            if (lanes[k].ovf)
            begin
                t = lanes[k].neg ? -ONE : TWO;
            end
            else if (lanes[k].neg)
            begin
                t = -mag - lbc_pkg::T_W'(lanes[k].rem != '0);
                if (t < -ONE)
                begin
                    t = -ONE;
                end
            end
            else
            begin
                t = (mag > TWO) ? TWO : mag;
            end
            if (!lanes[k].pz)
            begin
                if (lanes[k].pneg)
                begin
                    if (t > near)
                    begin
                        near = t;
                    end
                end
                else if (t < far)
                begin
                    far = t;
                end
            end
        end
        span_next.hit  = !carry.reject && (near <= far);
        span_next.near = near;
        span_next.far  = far;
        span_next.sx   = carry.sx;
        span_next.sy   = carry.sy;
        span_next.dx   = carry.dx;
        span_next.dy   = carry.dy;
    end

    always_comb
    begin
        prod_next.hit = span_reg.hit;
        prod_next.sx  = span_reg.sx;
        prod_next.sy  = span_reg.sy;
        prod_next.xn  = span_reg.dx * span_reg.near;
        prod_next.yn  = span_reg.dy * span_reg.near;
        prod_next.xf  = span_reg.dx * span_reg.far;
        prod_next.yf  = span_reg.dy * span_reg.far;
    end

    always_comb
    begin
        logic signed [lbc_pkg::PROD_W-1:0] xn;
        logic signed [lbc_pkg::PROD_W-1:0] yn;
        logic signed [lbc_pkg::PROD_W-1:0] xf;
        logic signed [lbc_pkg::PROD_W-1:0] yf;
        xn = (prod_reg.xn + HALF) >>> TF;
        yn = (prod_reg.yn + HALF) >>> TF;
        xf = (prod_reg.xf + HALF) >>> TF;
        yf = (prod_reg.yf + HALF) >>> TF;
        clip_next = '0;
        if (prod_reg.hit)
        begin
            clip_next.hit          = 1'b1;
            clip_next.clip_start_x = prod_reg.sx + xn[lbc_pkg::COORD_W-1:0];
            clip_next.clip_start_y = prod_reg.sy + yn[lbc_pkg::COORD_W-1:0];
            clip_next.clip_end_x   = prod_reg.sx + xf[lbc_pkg::COORD_W-1:0];
            clip_next.clip_end_y   = prod_reg.sy + yf[lbc_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            span_reg <= span_next;
        end
        if (en[1])
        begin
            prod_reg <= prod_next;
        end
        if (en[2])
        begin
            clip_reg <= clip_next;
        end
    end

    assign clip = clip_reg;

endmodule

// ===== src/line_segment_rect_clipper_top.sv =====
// Channel   Direction  Handshake                 Payload
// seg       in         seg_valid / seg_stall     lbc_pkg::seg_t
// clip      out        clip_valid / clip_stall   lbc_pkg::clip_t
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The pipeline has one setup stage, one restoring divider step per quotient bit,
// then span, multiply and output stages. One transaction is accepted per cycle
// while seg_stall is low; a stage takes new data whenever it is empty or the stage
// after it moves, so bubbles close up under a stall.
// Reset clears the valid bits and both rectangle registers; cfg_ready is always high.
module line_segment_rect_clipper_top #(
    parameter int T_FRAC_BITS = lbc_pkg::T_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            seg_valid,
    output logic                            seg_stall,
    input  lbc_pkg::seg_t                   seg,
    output logic                            clip_valid,
    input  logic                            clip_stall,
    output lbc_pkg::clip_t                  clip,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbc_pkg::RECT_W-1:0]      cfg_data
);

    localparam int NDIV = T_FRAC_BITS + 2;
    localparam int NS   = NDIV + 4;

    logic [lbc_pkg::RECT_W-1:0] width_reg;
    logic [lbc_pkg::RECT_W-1:0] height_reg;
    logic [NS-1:0]              valid_reg;
    logic [NS-1:0]              rdy;

    lbc_pkg::lane_t [lbc_pkg::LANES-1:0] front_lanes;
    lbc_pkg::carry_t                     front_carry;
    lbc_pkg::lane_t [lbc_pkg::LANES-1:0] div_lanes;
    lbc_pkg::carry_t                     div_carry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lbc_pkg::CFG_RECT_WIDTH:  width_reg  <= cfg_data;
                lbc_pkg::CFG_RECT_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rdy[NS-1] = !valid_reg[NS-1] || !clip_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= seg_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign seg_stall  = !rdy[0];
    assign clip_valid = valid_reg[NS-1];

    lbc_front #(
        .TF(T_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .en         (rdy[0]),
        .seg        (seg),
        .rect_width (width_reg),
        .rect_height(height_reg),
        .lanes      (front_lanes),
        .carry      (front_carry)
    );

    lbc_div_pipe #(
        .NDIV(NDIV)
    ) u_div (
        .clk      (clk),
        .en       (rdy[NDIV:1]),
        .lanes_in (front_lanes),
        .carry_in (front_carry),
        .lanes_out(div_lanes),
        .carry_out(div_carry)
    );

    lbc_back #(
        .TF(T_FRAC_BITS)
    ) u_back (
        .clk  (clk),
        .en   (rdy[NS-1:NDIV+1]),
        .lanes(div_lanes),
        .carry(div_carry),
        .clip (clip)
    );

endmodule

// ===== src/lbc_checker.sv =====
`include "line_segment_rect_clipper_top_macros.svh"

module lbc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           seg_stall,
    input logic           clip_valid,
    input logic           clip_stall,
    input lbc_pkg::clip_t clip,
    input logic           cfg_ready
);

    // A stalled result stays offered and unchanged.
    `LBC_ASSERT_NEXT(a_clip_hold_valid, clk, rst_n, clip_valid && clip_stall, clip_valid)
    `LBC_ASSERT_NEXT(a_clip_hold_data, clk, rst_n, clip_valid && clip_stall, $stable(clip))

    // A miss carries zero endpoints.
    `LBC_ASSERT_NOW(a_miss_zero, clk, rst_n, clip_valid && !clip.hit, clip == '0)

    // The input side only stalls when the pipeline is full and its output is held.
    `LBC_ASSERT_NOW(a_stall_cause, clk, rst_n, seg_stall, clip_valid && clip_stall)

    `LBC_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind line_segment_rect_clipper_top lbc_checker u_lbc_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;

    localparam longint TONE = longint'(1) << lbc_pkg::T_FRAC_BITS;
    localparam longint THALF = TONE / 2;
    localparam int DRAIN_CYCLES = lbc_pkg::T_FRAC_BITS + 16;
    localparam int HANG_LIMIT = 5000;
    localparam logic [lbc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [lbc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;
    localparam int RECT_MAX = (1 << lbc_pkg::RECT_W) - 1;

    typedef struct {
        logic [lbc_pkg::RECT_W-1:0] w;
        logic [lbc_pkg::RECT_W-1:0] h;
        lbc_pkg::seg_t              s;
        bit                         fixed;
        lbc_pkg::clip_t             exp;
    } row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          seg_valid = 1'b0;
    logic                          seg_stall;
    lbc_pkg::seg_t                 seg = '0;
    logic                          clip_valid;
    logic                          clip_stall = 1'b0;
    lbc_pkg::clip_t                clip;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [lbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lbc_pkg::RECT_W-1:0]    cfg_data = '0;

    logic [lbc_pkg::RECT_W-1:0] cur_w = '0;
    logic [lbc_pkg::RECT_W-1:0] cur_h = '0;
    lbc_pkg::clip_t             pending_clips[$];
    int                         mismatches = 0;
    int                         hang_count = 0;
    bit                         quiet = 1'b0;
    row_t                       rows[$];

    line_segment_rect_clipper_top DUT (
        .clk(clk), .rst_n(rst_n),
        .seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
        .clip_valid(clip_valid), .clip_stall(clip_stall), .clip(clip),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint floor_div(longint a, longint b);
        longint qt;
        longint r;
        qt = a / b;
        r = a % b;
        if (r != 0 && ((r < 0) != (b < 0)))
            qt = qt - 1;
        return qt;
    endfunction

    function automatic logic [lbc_pkg::COORD_W-1:0] lerp(longint s, longint d, longint t);
        longint v;
        v = s + floor_div(d * t + THALF, TONE);
        return v[lbc_pkg::COORD_W-1:0];
    endfunction

    function automatic lbc_pkg::clip_t clip_segment(lbc_pkg::seg_t s,
                                                    logic [lbc_pkg::RECT_W-1:0] w,
                                                    logic [lbc_pkg::RECT_W-1:0] h);
        longint sx, sy, dx, dy, lo, hi, t;
        longint p[4];
        longint q[4];
        bit ok;
        lbc_pkg::clip_t r;
        sx = longint'(s.start_x);
        sy = longint'(s.start_y);
        dx = longint'(s.end_x) - sx;
        dy = longint'(s.end_y) - sy;
        p[0] = -dx; p[1] = dx; p[2] = -dy; p[3] = dy;
        q[0] = sx; q[1] = longint'(w) - sx; q[2] = sy; q[3] = longint'(h) - sy;
        lo = 0;
        hi = TONE;
        ok = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            if (p[k] == 0)
            begin
                if (q[k] < 0 || (s.strict_mode && q[k] <= 0))
                    ok = 1'b0;
            end
            else
            begin
                t = floor_div(q[k] * TONE, p[k]);
                if (t < -TONE)
                    t = -TONE;
                if (t > 2 * TONE)
                    t = 2 * TONE;
                if (p[k] < 0)
                begin
                    if (t > lo)
                        lo = t;
                end
                else if (t < hi)
                    hi = t;
            end
        end
        if (lo > hi)
            ok = 1'b0;
        r = '0;
        if (ok)
        begin
            r.hit = 1'b1;
            r.clip_start_x = lerp(sx, dx, lo);
            r.clip_start_y = lerp(sy, dy, lo);
            r.clip_end_x = lerp(sx, dx, hi);
            r.clip_end_y = lerp(sy, dy, hi);
        end
        return r;
    endfunction

    function automatic logic [lbc_pkg::COORD_W-1:0] pick_coord(longint span);
        longint v;
        case ($urandom_range(0, 5))
            0: v = longint'($signed(lbc_pkg::COORD_W'($urandom)));
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = -524288;
                    1: v = 524287;
                    2: v = 0;
                    default: v = span;
                endcase
            end
            default: v = longint'($urandom_range(0, int'(span + span / 2))) - span / 4;
        endcase
        if (v > 524287)
            v = 524287;
        if (v < -524288)
            v = -524288;
        return v[lbc_pkg::COORD_W-1:0];
    endfunction

    function automatic bit roll_idle();
        return !quiet && ($urandom_range(0, 99) < 11);
    endfunction

    always @(negedge clk)
        clip_stall <= roll_idle();

    always @(posedge clk)
    begin
        if ((seg_valid && !seg_stall) || (clip_valid && !clip_stall) ||
            (cfg_valid && cfg_ready))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT)
        begin
            $display("line_segment_rect_clipper_top regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && clip_valid && !clip_stall)
        begin
            if (pending_clips.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected transaction on clip: %p", clip);
            end
            else if (clip !== pending_clips[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Clip mismatch: expected %p, actual %p",
                             pending_clips[0], clip);
                void'(pending_clips.pop_front());
            end
            else
                void'(pending_clips.pop_front());
        end
    end

    task automatic send_seg(input lbc_pkg::seg_t s, input bit fixed,
                            input lbc_pkg::clip_t exp);
        while (roll_idle())
        begin
            seg_valid <= 1'b0;
            @(negedge clk);
        end
        seg_valid <= 1'b1;
        seg <= s;
        do
            @(posedge clk);
        while (seg_stall);
        pending_clips.push_back(fixed ? exp : clip_segment(s, cur_w, cur_h));
        @(negedge clk);
    endtask

    task automatic drain();
        seg_valid <= 1'b0;
        while (pending_clips.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [lbc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lbc_pkg::RECT_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == lbc_pkg::CFG_RECT_WIDTH)
            cur_w = data;
        else if (idx == lbc_pkg::CFG_RECT_HEIGHT)
            cur_h = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_rect(input logic [lbc_pkg::RECT_W-1:0] w,
                            input logic [lbc_pkg::RECT_W-1:0] h);
        drain();
        write_reg(lbc_pkg::CFG_RECT_WIDTH, w);
        write_reg(lbc_pkg::CFG_RECT_HEIGHT, h);
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B,
                      lbc_pkg::RECT_W'($urandom));
    endtask

    function automatic row_t mk(int w, int h,
                                int sx, int sy, int ex, int ey, int strict,
                                int fixed, int hit, int cx0, int cy0, int cx1, int cy1);
        row_t r;
        r.w = lbc_pkg::RECT_W'(w);
        r.h = lbc_pkg::RECT_W'(h);
        r.s = {lbc_pkg::COORD_W'(sx), lbc_pkg::COORD_W'(sy), lbc_pkg::COORD_W'(ex),
               lbc_pkg::COORD_W'(ey), 1'(strict)};
        r.fixed = (fixed != 0);
        r.exp = {1'(hit), lbc_pkg::COORD_W'(cx0), lbc_pkg::COORD_W'(cy0),
                 lbc_pkg::COORD_W'(cx1), lbc_pkg::COORD_W'(cy1)};
        return r;
    endfunction

    initial
    begin
        lbc_pkg::seg_t s;
        logic [lbc_pkg::RECT_W-1:0] w, h;
        lbc_pkg::clip_t none;
        none = '0;
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 5, 3, 9, 1, 0, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(1600, 1600, -16, 100, -16, 200, 0, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(1600, 1600, 16, 16, 32, 48, 0, 1, 1, 16, 16, 32, 48));
        rows.push_back(mk(1600, 1600, 16, 16, 32, 48, 1, 1, 1, 16, 16, 32, 48));
        rows.push_back(mk(1600, 1600, 0, 0, 0, 1600, 1, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(1600, 1600, 0, 0, 0, 1600, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(1600, 1600, 1600, 1600, 1600, 1600, 1, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(1600, 1600, 1600, 1600, 1600, 1600, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(1600, 1600, -800, 800, 2400, 800, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(1600, 1600, 2400, 2400, -800, -800, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(1600, 1600, -100, 3000, 3000, -100, 1, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(1600, 1600, 2000, 0, 1900, 5000, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(1600, 1600, 800, 800, 801, 801, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(RECT_MAX, RECT_MAX, -524288, -524288, 524287, 524287, 0,
                          0, 0, 0, 0, 0, 0));
        rows.push_back(mk(RECT_MAX, RECT_MAX, 524287, -524288, -524288, 524287, 1,
                          0, 0, 0, 0, 0, 0));
        rows.push_back(mk(RECT_MAX, RECT_MAX, 524287, 524287, 524287, 524287, 0,
                          0, 0, 0, 0, 0, 0));
        rows.push_back(mk(RECT_MAX, RECT_MAX, -524288, 0, -524288, 0, 0,
                          1, 0, 0, 0, 0, 0));
        rows.push_back(mk(RECT_MAX, 0, 1, 0, 524287, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(RECT_MAX, 0, 1, 0, 524287, 0, 1, 1, 0, 0, 0, 0, 0));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].w != cur_w || rows[i].h != cur_h)
                set_rect(rows[i].w, rows[i].h);
            send_seg(rows[i].s, rows[i].fixed, rows[i].exp);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    w = lbc_pkg::RECT_W'($urandom_range(16, 4000));
                    h = lbc_pkg::RECT_W'($urandom_range(16, 4000));
                end
                1:
                begin
                    w = lbc_pkg::RECT_W'(RECT_MAX);
                    h = lbc_pkg::RECT_W'(RECT_MAX);
                end
                2:
                begin
                    w = '0;
                    h = lbc_pkg::RECT_W'($urandom_range(16, 4000));
                end
                3:
                begin
                    w = lbc_pkg::RECT_W'($urandom);
                    h = lbc_pkg::RECT_W'($urandom);
                end
                4:
                begin
                    w = lbc_pkg::RECT_W'($urandom_range(1, 64));
                    h = '0;
                end
                default:
                begin
                    w = lbc_pkg::RECT_W'($urandom_range(100, 20000));
                    h = lbc_pkg::RECT_W'($urandom_range(100, 20000));
                end
            endcase
            set_rect(w, h);
            for (int n = 0; n < 170; n++)
            begin
                quiet = (ph == 3);
                s.start_x = pick_coord(longint'(w));
                s.start_y = pick_coord(longint'(h));
                s.end_x = pick_coord(longint'(w));
                s.end_y = pick_coord(longint'(h));
                s.strict_mode = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 15))
                    0, 1: s.end_x = s.start_x;
                    2, 3: s.end_y = s.start_y;
                    4: begin s.end_x = s.start_x; s.end_y = s.start_y; end
                    default: ;
                endcase
                send_seg(s, 1'b0, none);
            end
        end
        quiet = 1'b0;
        drain();

        if (mismatches == 0)
            $display("line_segment_rect_clipper_top regression: pass");
        else
            $display("line_segment_rect_clipper_top regression: fail");
        $finish;
    end
endmodule
